@@ rtl/core/erxaf_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethernet receive address filter package
// Shared types and constants for the receive destination-address filter.
// ----------------------------------------------------------------------------
package erxaf_pkg;

	localparam int MAX_FRAME_DEF = 1536;
	localparam int HDR_LEN       = 14;
	localparam int ADDR_LEN      = 6;
	localparam int LEN_W         = 11;
	localparam logic [7:0] BCAST_BYTE = 8'hFF;

	// Register byte addresses (8 bytes per register).
	localparam logic [3:0] ADDR_STATION = 4'h0;

	// One received byte as held in the input stage.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_last;
	} erxaf_item_t;

	// One result request toward the output stage.
	typedef struct packed {
		logic             has_byte;
		logic [7:0]       payload_byte;
		logic             frame_end;
		logic             accepted;
		logic [LEN_W-1:0] payload_length;
	} erxaf_result_t;

endpackage

@@ rtl/core/erxaf_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input stage
// Registers one received byte per request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module erxaf_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic                  s_tlast,   // frame_last
	input  logic                  take,
	output logic                  valid_s1,
	output erxaf_pkg::erxaf_item_t item_s1
);

	logic load;

	assign s_tready = !valid_s1 || take;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.rx_byte    <= s_tdata;
			item_s1.frame_last <= s_tlast;
		end
	end

endmodule

@@ rtl/core/erxaf_filter_core.sv @@
// ----------------------------------------------------------------------------
// Filter core
// Per-frame byte counter and address match flags, with the result decision.
// ----------------------------------------------------------------------------
module erxaf_filter_core #(
	parameter int MAX_FRAME = erxaf_pkg::MAX_FRAME_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [47:0]             station_address,
	input  logic                    valid_s1,
	input  erxaf_pkg::erxaf_item_t  item_s1,
	input  logic                    out_free,
	output logic                    take,
	output logic                    produce,
	output erxaf_pkg::erxaf_result_t result
);

	localparam int PW = $clog2(MAX_FRAME + 1);
	localparam int LW = (PW > erxaf_pkg::LEN_W) ? PW : erxaf_pkg::LEN_W;

	logic [PW-1:0] byte_position_q;
	logic          broadcast_match_q;
	logic          station_match_q;

	logic [PW-1:0] pos_next;
	logic          bm_next;
	logic          sm_next;
	logic          counted;
	logic          in_addr;
	logic          emit;
	logic          ok;
	logic [7:0]    own_byte;
	logic [LW-1:0] len_diff;

	always_comb begin
		unique case (byte_position_q[2:0])
			3'd0:    own_byte = station_address[47:40];
			3'd1:    own_byte = station_address[39:32];
			3'd2:    own_byte = station_address[31:24];
			3'd3:    own_byte = station_address[23:16];
			3'd4:    own_byte = station_address[15:8];
			3'd5:    own_byte = station_address[7:0];
			default: own_byte = 8'h00;
		endcase
	end

	always_comb begin
		counted  = byte_position_q < PW'(MAX_FRAME);
		in_addr  = byte_position_q < PW'(erxaf_pkg::ADDR_LEN);
		pos_next = counted ? byte_position_q + PW'(1) : byte_position_q;
		bm_next  = broadcast_match_q;
		sm_next  = station_match_q;
		if (counted && in_addr) begin
			if (item_s1.rx_byte != erxaf_pkg::BCAST_BYTE) begin
				bm_next = 1'b0;
			end
			if (item_s1.rx_byte != own_byte) begin
				sm_next = 1'b0;
			end
		end
		emit = counted && (byte_position_q >= PW'(erxaf_pkg::HDR_LEN)) &&
			(broadcast_match_q || station_match_q);
		ok = (bm_next || sm_next) && (pos_next >= PW'(erxaf_pkg::HDR_LEN));
		len_diff = LW'(pos_next) - LW'(erxaf_pkg::HDR_LEN);

		produce = emit || item_s1.frame_last;
		// Bytes without a result never wait on the output register.
		take    = valid_s1 && (out_free || !produce);

		result.has_byte       = emit;
		result.payload_byte   = emit ? item_s1.rx_byte : 8'h00;
		result.frame_end      = item_s1.frame_last;
		result.accepted       = item_s1.frame_last && ok;
		result.payload_length = (item_s1.frame_last && ok) ?
			len_diff[erxaf_pkg::LEN_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			broadcast_match_q <= 1'b1;
			station_match_q   <= 1'b1;
		end else if (take) begin
			if (item_s1.frame_last) begin
				byte_position_q   <= '0;
				broadcast_match_q <= 1'b1;
				station_match_q   <= 1'b1;
			end else begin
				byte_position_q   <= pos_next;
				broadcast_match_q <= bm_next;
				station_match_q   <= sm_next;
			end
		end
	end

endmodule

@@ rtl/core/erxaf_out_stage.sv @@
// ----------------------------------------------------------------------------
// Output stage
// Result register toward the master-side stream.
// ----------------------------------------------------------------------------
module erxaf_out_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  erxaf_pkg::erxaf_result_t result,
	output logic                     out_free,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [23:0]              m_tdata,  // [7:0] payload_byte, [18:8] payload_length
	output logic [1:0]               m_tuser,  // [0] has_byte, [1] accepted
	output logic                     m_tlast   // frame_end
);

	erxaf_pkg::erxaf_result_t res_q;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	assign m_tdata = {5'b0, res_q.payload_length, res_q.payload_byte};
	assign m_tuser = {res_q.accepted, res_q.has_byte};
	assign m_tlast = res_q.frame_end;

endmodule

@@ rtl/core/ethernet_rx_address_filter.sv @@
// ----------------------------------------------------------------------------
// Ethernet receive destination-address filter
// Checks the destination address of each received frame against broadcast and
// the station address, strips the header and passes on payload bytes.
// ----------------------------------------------------------------------------
// A byte is registered in the input stage; its result then loads the result register when that is free.
// Throughput: one byte per cycle while the result register is not stalled, set by the single input and result register.
// Bytes that cause no result never stall on the output register.
// Reset: arst_n clears the frame state and station address at once.
module ethernet_rx_address_filter #(
	parameter int MAX_FRAME = erxaf_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // frame_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [18:8] payload_length
	output logic [1:0]  m_tuser,   // [0] has_byte, [1] accepted
	output logic        m_tlast    // frame_end
);

	logic [47:0]              station_address_q;
	logic                     take;
	logic                     produce;
	logic                     valid_s1;
	logic                     out_free;
	erxaf_pkg::erxaf_item_t   item_s1;
	erxaf_pkg::erxaf_result_t result;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			(paddr[3] == erxaf_pkg::ADDR_STATION[3])) begin
			station_address_q <= pwdata[47:0];
		end
	end

	assign prdata = (paddr[3] == erxaf_pkg::ADDR_STATION[3]) ?
		{16'b0, station_address_q} : 64'b0;

	erxaf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	erxaf_filter_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.station_address (station_address_q),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1),
		.out_free        (out_free),
		.take            (take),
		.produce         (produce),
		.result          (result)
	);

	erxaf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && produce),
		.result   (result),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/core/erxaf_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches the result stream of the address filter for consistency.
// ----------------------------------------------------------------------------
module erxaf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	// A result that does not end a frame always carries a payload byte.
	a_mid_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[0])
		else $error("empty result inside a frame");

	// The frame summary shows only on the final result.
	a_summary_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tuser[1] && (m_tdata[18:8] == 11'd0))
		else $error("frame summary before frame end");

	// Without a payload byte the byte field is zero.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("payload byte set without has_byte");

endmodule

bind ethernet_rx_address_filter erxaf_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ verif/erxaf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Receive address filter checker
// Watches the configuration port and both stream channels of the filter. It
// keeps its own copy of the station address and of the per-frame match state,
// predicts the result of every accepted byte and compares each delivered
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module erxaf_tb_checker #(
	parameter int MAX_FRAME = erxaf_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic [63:0] prdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // frame_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] payload_byte, [18:8] payload_length
	input  logic [1:0]  m_tuser,   // [0] has_byte, [1] accepted
	input  logic        m_tlast,   // frame_end
	output int          mismatches,
	output int          results_due
);

	localparam int PW = $clog2(MAX_FRAME + 1);

	logic [47:0]              station_addr;
	logic [PW-1:0]            byte_count;
	logic                     bcast_ok;
	logic                     own_ok;
	erxaf_pkg::erxaf_result_t frame_results_q[$];
	int                       mismatch_count;

	function automatic void check_field(input string what, input logic [47:0] want,
			input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatch_count++;
		end
	endfunction

	// Advances the frame state by one received byte and queues the result it
	// causes, if any.
	function automatic void filter_rx_byte(input logic [7:0] b, input logic last);
		erxaf_pkg::erxaf_result_t res;
		logic                     emit;
		logic                     ok;
		emit = 1'b0;
		if (byte_count < MAX_FRAME) begin
			if (byte_count < erxaf_pkg::ADDR_LEN) begin
				if (b != erxaf_pkg::BCAST_BYTE)
					bcast_ok = 1'b0;
				if (b != station_addr[8*(erxaf_pkg::ADDR_LEN-1-int'(byte_count)) +: 8])
					own_ok = 1'b0;
			end else if (byte_count >= erxaf_pkg::HDR_LEN) begin
				emit = bcast_ok || own_ok;
			end
			byte_count = byte_count + PW'(1);
		end
		if (emit || last) begin
			res                = '0;
			res.has_byte       = emit;
			res.payload_byte   = emit ? b : 8'h00;
			res.frame_end      = last;
			if (last) begin
				ok                 = (bcast_ok || own_ok) && (byte_count >= erxaf_pkg::HDR_LEN);
				res.accepted       = ok;
				res.payload_length = ok ?
					erxaf_pkg::LEN_W'(byte_count - PW'(erxaf_pkg::HDR_LEN)) : '0;
				byte_count = '0;
				bcast_ok   = 1'b1;
				own_ok     = 1'b1;
			end
			frame_results_q.push_back(res);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		erxaf_pkg::erxaf_result_t want;
		if (!arst_n) begin
			station_addr   = '0;
			byte_count     = '0;
			bcast_ok       = 1'b1;
			own_ok         = 1'b1;
			mismatch_count = 0;
			frame_results_q.delete();
		end else begin
			// A result leaving now belongs to an earlier byte, so it is checked
			// before this cycle's byte is predicted.
			if (m_tvalid && m_tready) begin
				if (frame_results_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0h %0h %0b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatch_count++;
				end else begin
					want = frame_results_q.pop_front();
					check_field("has_byte", 48'(want.has_byte), 48'(m_tuser[0]));
					check_field("payload_byte", 48'(want.payload_byte), 48'(m_tdata[7:0]));
					check_field("frame_end", 48'(want.frame_end), 48'(m_tlast));
					check_field("accepted", 48'(want.accepted), 48'(m_tuser[1]));
					check_field("payload_length", 48'(want.payload_length),
						48'(m_tdata[18:8]));
				end
			end
			if (s_tvalid && s_tready)
				filter_rx_byte(s_tdata, s_tlast);
			if (psel && penable && pready && paddr == erxaf_pkg::ADDR_STATION) begin
				if (pwrite)
					station_addr = pwdata[47:0];
				else
					check_field("station_address readback", station_addr, prdata[47:0]);
			end
		end
		mismatches  <= mismatch_count;
		results_due <= frame_results_q.size();
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Receive address filter testbench
// Sends Ethernet frames addressed to broadcast, to the station, near misses
// and random addresses, of runt, header-only, normal and oversized lengths,
// under several station address settings. The sender works in bursts and the
// receiver stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int PHASE_ITEMS    = 80;

	typedef enum logic [1:0] {
		DST_BCAST,
		DST_STATION,
		DST_NEAR,
		DST_OTHER
	} dst_kind_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = erxaf_pkg::ADDR_STATION;
	logic [63:0] pwdata   = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
	logic        s_tlast  = 1'b0; // frame_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // [7:0] payload_byte, [18:8] payload_length
	logic [1:0]  m_tuser;         // [0] has_byte, [1] accepted
	logic        m_tlast;         // frame_end

	int          mismatches;
	int          results_due;
	logic [47:0] station_now = '0;
	int          sent_items  = 0;
	int          burst_left  = 0;
	logic        hold_req    = 1'b0;
	logic        hold_done   = 1'b0;
	int          hold_left   = 0;
	int          ready_cycle = 0;
	int          ready_mode  = 0;
	int          idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ethernet_rx_address_filter dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	erxaf_tb_checker #(.MAX_FRAME(erxaf_pkg::MAX_FRAME_DEF)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches), .results_due(results_due)
	);

	// Receiver: the stall pattern is drawn anew from four modes; one long hold-off on request.
	always @(posedge clk) begin
		ready_cycle <= ready_cycle + 1;
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
			m_tready  <= 1'b0;
		end else begin
			if (ready_cycle % 64 == 0)
				ready_mode <= $urandom_range(0, 3);
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (ready_cycle[1:0] != 2'b11);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Ends on the edge after the access so that a following access starts in a
	// later time step.
	task automatic station_access(input logic wr, input logic [47:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= erxaf_pkg::ADDR_STATION;
		pwdata  <= {16'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one byte and returns at the edge where it is taken. Bursts and
	// gaps are drawn here so that idling lands anywhere within a frame.
	task automatic push_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25)
				: $urandom_range(0, 4);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_frame(input dst_kind_t kind, input int len);
		logic [7:0] dst [6];
		int         k;
		for (int i = 0; i < 6; i++) begin
			case (kind)
				DST_BCAST: dst[i] = erxaf_pkg::BCAST_BYTE;
				DST_OTHER: dst[i] = 8'($urandom());
				default:   dst[i] = station_now[8*(5-i) +: 8];
			endcase
		end
		// A near miss differs from the station address in a single bit.
		if (kind == DST_NEAR) begin
			k      = $urandom_range(0, 5);
			dst[k] = dst[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		for (int i = 0; i < len; i++)
			push_byte((i < 6) ? dst[i] : 8'($urandom()), i == len - 1);
	endtask

	task automatic random_frame();
		int        pick;
		int        len;
		dst_kind_t kind;
		pick = $urandom_range(0, 99);
		kind = (pick < 40) ? DST_STATION : (pick < 65) ? DST_BCAST
			: (pick < 85) ? DST_NEAR : DST_OTHER;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			len = $urandom_range(1, erxaf_pkg::HDR_LEN - 1);
		else if (pick < 14)
			len = $urandom_range(erxaf_pkg::HDR_LEN, erxaf_pkg::HDR_LEN + 1);
		else if (pick < 97)
			len = $urandom_range(erxaf_pkg::HDR_LEN + 2, 72);
		else
			len = $urandom_range(73, 300);
		send_frame(kind, len);
	endtask

	initial begin
		logic [47:0] addr_plan [5];
		int          goal;
		addr_plan[0] = {16'($urandom()), 32'($urandom())};
		addr_plan[1] = 48'hFFFF_FFFF_FFFF;
		addr_plan[2] = 48'h0000_0000_0000;
		addr_plan[3] = {16'($urandom()), 32'($urandom())};
		addr_plan[4] = 48'h0000_0000_0001;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		station_access(1'b0, '0);
		for (int p = 0; p < 5; p++) begin
			station_now = addr_plan[p];
			station_access(1'b1, station_now);
			station_access(1'b0, '0);
			if (p == 0) begin
				// Runt, header-only and minimal payload frames.
				send_frame(DST_BCAST, 1);
				send_frame(DST_BCAST, erxaf_pkg::HDR_LEN);
				send_frame(DST_STATION, erxaf_pkg::HDR_LEN + 1);
			end
			if (p == 1) begin
				// Oversized, with ignored trailing bytes past the maximum size.
				send_frame(DST_BCAST, erxaf_pkg::MAX_FRAME_DEF + $urandom_range(1, 8));
			end
			if (p == 2)
				hold_req <= 1'b1;
			goal = sent_items + PHASE_ITEMS;
			while (sent_items < goal)
				random_frame();
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (results_due != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
		end
		if (mismatches == 0 && results_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ ethernet_rx_address_filter.f @@
rtl/core/erxaf_pkg.sv
rtl/core/erxaf_in_stage.sv
rtl/core/erxaf_filter_core.sv
rtl/core/erxaf_out_stage.sv
rtl/core/ethernet_rx_address_filter.sv
rtl/core/erxaf_checker.sv
verif/erxaf_checker.sv
verif/tb_top.sv
